// ===== rtl/core/sfu_pkg.sv =====
// sfu_pkg: shared constants, mode codes and pipeline context types
// for the steering force unit; no dependencies
package sfu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SEEK_CLAMP_INT = 20;

	localparam logic [1:0] FN_CHASE = 2'd0;
	localparam logic [1:0] FN_SEEK  = 2'd1;
	localparam logic [1:0] FN_AVOID = 2'd2;
	localparam logic [1:0] FN_NONE  = 2'd3;

	typedef struct packed {
		logic [30:0] hx;
		logic [30:0] hy;
		logic        nx;
		logic        ny;
		logic        sh;
		logic [31:0] lh;
	} geo_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic [30:0]        speed;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic [31:0]        vxa;
		logic [31:0]        vya;
		logic [31:0]        mstr;
		logic               mneg;
		geo_t               g1;
		geo_t               g2;
		geo_t               gs;
		logic               degen;
		logic               ovf;
		logic [62:0]        sprod;
		logic [30:0]        t;
		logic signed [31:0] px;
		logic signed [31:0] py;
	} ctx_t;

endpackage

// ===== rtl/core/sfu_cfg_if.sv =====
// sfu_cfg_if: configuration write channel carrying the seek clamp word
// no dependencies
interface sfu_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/sfu_in_if.sv =====
// sfu_in_if: input channel carrying one agent steering request word
// no dependencies
interface sfu_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic signed [31:0] agent_x;
	logic signed [31:0] agent_y;
	logic signed [31:0] goal_x;
	logic signed [31:0] goal_y;
	logic signed [31:0] goal_vel_x;
	logic signed [31:0] goal_vel_y;
	logic signed [31:0] magnitude;
	logic [30:0]        pursuit_speed;
	logic signed [31:0] accum_in_x;
	logic signed [31:0] accum_in_y;

	modport source (output valid, output func, output agent_x, output agent_y,
		output goal_x, output goal_y, output goal_vel_x, output goal_vel_y,
		output magnitude, output pursuit_speed, output accum_in_x, output accum_in_y,
		input ready);
	modport sink (input valid, input func, input agent_x, input agent_y,
		input goal_x, input goal_y, input goal_vel_x, input goal_vel_y,
		input magnitude, input pursuit_speed, input accum_in_x, input accum_in_y,
		output ready);
endinterface

// ===== rtl/core/sfu_out_if.sv =====
// sfu_out_if: result channel carrying the updated accumulated force word
// no dependencies
interface sfu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] accum_out_x;
	logic signed [31:0] accum_out_y;
	logic               degenerate;

	modport source (output valid, output accum_out_x, output accum_out_y,
		output degenerate, input ready);
	modport sink (input valid, input accum_out_x, input accum_out_y,
		input degenerate, output ready);
endinterface

// ===== rtl/core/sfu_isqrt.sv =====
// sfu_isqrt: pipelined floor square root, one root bit per stage
// carries a sideband word of any type alongside; no dependencies
module sfu_isqrt #(
	parameter int  RW = 32,
	parameter type side_t = logic
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [2*RW-1:0] in_n,
	input  side_t           in_side,
	output logic            out_valid,
	output logic [RW-1:0]   out_root,
	output side_t           out_side
);

	logic            valid_s [RW];
	logic [RW:0]     rem_s   [RW];
	logic [RW-1:0]   root_s  [RW];
	logic [2*RW-1:0] n_s     [RW];
	side_t           side_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic            pv;
		logic [RW:0]     prem;
		logic [RW-1:0]   proot;
		logic [2*RW-1:0] pn;
		side_t           pside;
		logic [RW+2:0]   shv;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            take;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign prem = '0;
			assign proot = '0;
			assign pn = in_n;
			assign pside = in_side;
		end else begin : g_next
			assign pv = valid_s[k-1];
			assign prem = rem_s[k-1];
			assign proot = root_s[k-1];
			assign pn = n_s[k-1];
			assign pside = side_s[k-1];
		end

		assign shv = {prem, pn[2*RW-1 -: 2]};
		assign trial = {1'b0, proot, 2'b01};
		assign take = shv >= trial;
		assign diff = shv - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= take ? diff[RW:0] : shv[RW:0];
				root_s[k] <= {proot[RW-2:0], take};
				n_s[k] <= {pn[2*RW-3:0], 2'b00};
				side_s[k] <= pside;
			end
		end
	end

	assign out_valid = valid_s[RW-1];
	assign out_root = root_s[RW-1];
	assign out_side = side_s[RW-1];

endmodule

// ===== rtl/core/sfu_div.sv =====
// sfu_div: pipelined restoring divider, one quotient bit per stage,
// several numerator lanes over one shared divisor; no dependencies
module sfu_div #(
	parameter int  QW = 32,
	parameter int  DW = 32,
	parameter int  LANES = 1,
	parameter type side_t = logic,
	localparam int CW = DW + QW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [CW-1:0] in_num [LANES],
	input  logic [DW-1:0] in_den,
	input  side_t         in_side,
	output logic          out_valid,
	output logic [QW-1:0] out_quo [LANES],
	output side_t         out_side
);

	logic          valid_s [QW];
	logic [DW-1:0] den_s   [QW];
	side_t         side_s  [QW];
	logic [CW-1:0] rem_s   [QW][LANES];
	logic [QW-1:0] quo_s   [QW][LANES];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic          pv;
		logic [DW-1:0] pden;
		side_t         pside;
		logic [CW-1:0] dsh;

		if (k == 0) begin : g_first
			assign pv = in_valid;
			assign pden = in_den;
			assign pside = in_side;
		end else begin : g_next
			assign pv = valid_s[k-1];
			assign pden = den_s[k-1];
			assign pside = side_s[k-1];
		end

		assign dsh = CW'(pden) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k] <= pden;
				side_s[k] <= pside;
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [CW-1:0] prem;
			logic [QW-1:0] pquo;
			logic          take;

			if (k == 0) begin : g_first
				assign prem = in_num[l];
				assign pquo = '0;
			end else begin : g_next
				assign prem = rem_s[k-1][l];
				assign pquo = quo_s[k-1][l];
			end

			assign take = prem >= dsh;

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= take ? prem - dsh : prem;
					quo_s[k][l] <= {pquo[QW-2:0], take};
				end
			end
		end
	end

	assign out_valid = valid_s[QW-1];
	assign out_side = side_s[QW-1];
	for (genvar l = 0; l < LANES; l++) begin : g_out
		assign out_quo[l] = quo_s[QW-1][l];
	end

endmodule

// ===== rtl/core/steering_force_unit_core.sv =====
// steering_force_unit_core: chase / seek / avoid steering force pipeline
// accepts one word per cycle while no result waits unaccepted; built from
// two 32-stage square roots and a 31- and a 32-stage divider in line
// the whole pipeline advances together and holds while a result waits
// reset clears valid bits; seek clamp resets to 20.0
// uses sfu_pkg, sfu_*_if, sfu_isqrt, sfu_div
module steering_force_unit_core
	import sfu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sfu_cfg_if.sink   cfg,
	sfu_in_if.sink    item,
	sfu_out_if.source result
);

	localparam logic [31:0] MAG_CAP = 32'h8000_0000;

	function automatic geo_t measure(input logic signed [32:0] dx,
			input logic signed [32:0] dy);
		logic [32:0] ux;
		logic [32:0] uy;
		logic        s;
		geo_t        g;
		ux = dx[32] ? 33'(-dx) : 33'(dx);
		uy = dy[32] ? 33'(-dy) : 33'(dy);
		s = ux[31] | uy[31];
		g.nx = dx[32];
		g.ny = dy[32];
		g.sh = s;
		g.hx = s ? ux[31:1] : ux[30:0];
		g.hy = s ? uy[31:1] : uy[30:0];
		g.lh = '0;
		return g;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fff_ffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	logic        en;
	logic [30:0] seek_clamp_q;

	assign en = !result.valid || result.ready;
	assign item.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seek_clamp_q <= 31'(SEEK_CLAMP_INT << FRAC_BITS);
		end else if (cfg.valid) begin
			seek_clamp_q <= cfg.data;
		end
	end

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic v_s11, v_s12, v_s13, v_s14, v_s15, v_s16;
	ctx_t c_s1, c_s2, c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	ctx_t c_s11, c_s12, c_s13, c_s14, c_s15;

	logic signed [32:0] dx_s1, dy_s1, dx_s10, dy_s10;
	logic [61:0]        sqx_s3, sqy_s3, sqx_s12, sqy_s12;
	logic [62:0]        sum_s4, sum_s13;
	logic [30:0]        var_s5;
	logic [63:0]        num_s5, num_s6;
	logic [32:0]        den_s5, den_s6;
	logic [62:0]        pvx_s8, pvy_s8, mx_s15, my_s15;
	logic signed [31:0] res_x_s16, res_y_s16;
	logic               dg_s16;

	logic        sq1_valid, sq2_valid, d1_valid, d2_valid;
	logic [31:0] sq1_root, sq2_root;
	ctx_t        sq1_side, sq2_side, d1_side, d2_side;
	logic [63:0] d1_num [1];
	logic [30:0] d1_quo [1];
	logic [63:0] d2_num [2];
	logic [31:0] d2_quo [2];

	ctx_t               n1, n2, n5, n6, n7, n9, n11, n14, n16;
	logic [32:0]        len5;
	logic [62:0]        sp7, shx9, shy9;
	logic signed [63:0] sumx9, sumy9, ox16, oy16;
	logic               act16;

	always_comb begin
		n1 = '0;
		n1.func = item.func;
		n1.ax = item.agent_x;
		n1.ay = item.agent_y;
		n1.gx = item.goal_x;
		n1.gy = item.goal_y;
		n1.vx = item.goal_vel_x;
		n1.vy = item.goal_vel_y;
		n1.speed = item.pursuit_speed;
		n1.fx = item.accum_in_x;
		n1.fy = item.accum_in_y;
		n1.vxa = item.goal_vel_x[31] ? 32'(-item.goal_vel_x) : item.goal_vel_x;
		n1.vya = item.goal_vel_y[31] ? 32'(-item.goal_vel_y) : item.goal_vel_y;
		n1.mstr = item.magnitude[31] ? 32'(-item.magnitude) : item.magnitude;
		n1.mneg = item.magnitude[31];
	end

	always_comb begin
		n2 = c_s1;
		n2.g1 = measure(dx_s1, dy_s1);
	end

	always_comb begin
		n5 = sq1_side;
		n5.g1.lh = sq1_root;
		len5 = {1'b0, sq1_root} << sq1_side.g1.sh;
		case (sq1_side.func)
			FN_CHASE: n5.degen = sq1_side.speed == '0;
			FN_SEEK, FN_AVOID: n5.degen = sq1_root == '0;
			default: n5.degen = 1'b0;
		endcase
	end

	always_comb begin
		n6 = c_s5;
		n6.ovf = num_s5 >= {den_s5, 31'b0};
		n6.sprod = c_s5.mstr * var_s5;
	end

	always_comb begin
		n7 = d1_side;
		sp7 = d1_side.sprod >> FRAC_BITS;
		case (d1_side.func)
			FN_CHASE: n7.t = d1_side.ovf ? '1 : d1_quo[0];
			FN_SEEK: begin
				n7.mstr = (sp7 > 63'(MAG_CAP)) ? MAG_CAP : sp7[31:0];
				n7.mneg = !d1_side.mneg;
			end
			FN_AVOID: n7.mstr = d1_side.ovf ? MAG_CAP : {1'b0, d1_quo[0]};
			default: n7.t = '0;
		endcase
	end

	always_comb begin
		n9 = c_s8;
		shx9 = pvx_s8 >> FRAC_BITS;
		shy9 = pvy_s8 >> FRAC_BITS;
		sumx9 = c_s8.vx[31] ? 64'(c_s8.gx) - $signed({1'b0, shx9})
			: 64'(c_s8.gx) + $signed({1'b0, shx9});
		sumy9 = c_s8.vy[31] ? 64'(c_s8.gy) - $signed({1'b0, shy9})
			: 64'(c_s8.gy) + $signed({1'b0, shy9});
		n9.px = sat32(sumx9);
		n9.py = sat32(sumy9);
	end

	always_comb begin
		n11 = c_s10;
		n11.g2 = measure(dx_s10, dy_s10);
	end

	always_comb begin
		n14 = sq2_side;
		n14.g2.lh = sq2_root;
		if (sq2_side.func == FN_CHASE) begin
			n14.gs = n14.g2;
			n14.degen = sq2_side.degen || (sq2_root == '0);
		end else begin
			n14.gs = sq2_side.g1;
		end
	end

	always_comb begin
		n16 = d2_side;
		act16 = !n16.degen && (n16.func != FN_NONE);
		ox16 = (n16.gs.nx ^ n16.mneg) ? 64'(n16.fx) - $signed({32'b0, d2_quo[0]})
			: 64'(n16.fx) + $signed({32'b0, d2_quo[0]});
		oy16 = (n16.gs.ny ^ n16.mneg) ? 64'(n16.fy) - $signed({32'b0, d2_quo[1]})
			: 64'(n16.fy) + $signed({32'b0, d2_quo[1]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0; v_s16 <= 1'b0;
		end else if (en) begin
			v_s1 <= item.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= sq1_valid;
			v_s6 <= v_s5;
			v_s7 <= d1_valid;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= sq2_valid;
			v_s15 <= v_s14;
			v_s16 <= d2_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1 <= n1;
			dx_s1 <= {item.agent_x[31], item.agent_x} - {item.goal_x[31], item.goal_x};
			dy_s1 <= {item.agent_y[31], item.agent_y} - {item.goal_y[31], item.goal_y};

			c_s2 <= n2;

			c_s3 <= c_s2;
			sqx_s3 <= c_s2.g1.hx * c_s2.g1.hx;
			sqy_s3 <= c_s2.g1.hy * c_s2.g1.hy;

			c_s4 <= c_s3;
			sum_s4 <= sqx_s3 + sqy_s3;

			c_s5 <= n5;
			var_s5 <= (len5 < {2'b00, seek_clamp_q}) ? len5[30:0] : seek_clamp_q;
			num_s5 <= (sq1_side.func == FN_CHASE) ? 64'(len5) << FRAC_BITS
				: 64'(sq1_side.mstr) << FRAC_BITS;
			case (sq1_side.func)
				FN_CHASE: den_s5 <= {2'b00, sq1_side.speed};
				FN_AVOID: den_s5 <= len5;
				default: den_s5 <= 33'd1;
			endcase

			c_s6 <= n6;
			num_s6 <= num_s5;
			den_s6 <= den_s5;

			c_s7 <= n7;

			c_s8 <= c_s7;
			pvx_s8 <= c_s7.vxa * c_s7.t;
			pvy_s8 <= c_s7.vya * c_s7.t;

			c_s9 <= n9;

			c_s10 <= c_s9;
			dx_s10 <= {c_s9.px[31], c_s9.px} - {c_s9.ax[31], c_s9.ax};
			dy_s10 <= {c_s9.py[31], c_s9.py} - {c_s9.ay[31], c_s9.ay};

			c_s11 <= n11;

			c_s12 <= c_s11;
			sqx_s12 <= c_s11.g2.hx * c_s11.g2.hx;
			sqy_s12 <= c_s11.g2.hy * c_s11.g2.hy;

			c_s13 <= c_s12;
			sum_s13 <= sqx_s12 + sqy_s12;

			c_s14 <= n14;

			c_s15 <= c_s14;
			mx_s15 <= c_s14.mstr * c_s14.gs.hx;
			my_s15 <= c_s14.mstr * c_s14.gs.hy;

			res_x_s16 <= act16 ? sat32(ox16) : n16.fx;
			res_y_s16 <= act16 ? sat32(oy16) : n16.fy;
			dg_s16 <= n16.degen;
		end
	end

	sfu_isqrt #(.RW(32), .side_t(ctx_t)) u_sqrt1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s4), .in_n({1'b0, sum_s4}), .in_side(c_s4),
		.out_valid(sq1_valid), .out_root(sq1_root), .out_side(sq1_side)
	);

	assign d1_num[0] = num_s6;

	sfu_div #(.QW(31), .DW(33), .LANES(1), .side_t(ctx_t)) u_div1 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s6), .in_num(d1_num), .in_den(den_s6), .in_side(c_s6),
		.out_valid(d1_valid), .out_quo(d1_quo), .out_side(d1_side)
	);

	sfu_isqrt #(.RW(32), .side_t(ctx_t)) u_sqrt2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s13), .in_n({1'b0, sum_s13}), .in_side(c_s13),
		.out_valid(sq2_valid), .out_root(sq2_root), .out_side(sq2_side)
	);

	assign d2_num[0] = {1'b0, mx_s15};
	assign d2_num[1] = {1'b0, my_s15};

	sfu_div #(.QW(32), .DW(32), .LANES(2), .side_t(ctx_t)) u_div2 (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(v_s15), .in_num(d2_num), .in_den(c_s15.gs.lh), .in_side(c_s15),
		.out_valid(d2_valid), .out_quo(d2_quo), .out_side(d2_side)
	);

	assign result.valid = v_s16;
	assign result.accum_out_x = res_x_s16;
	assign result.accum_out_y = res_y_s16;
	assign result.degenerate = dg_s16;

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> v_s1)
		else $error("accepted word did not enter the pipeline");

	a_strength_cap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> c_s7.mstr <= MAG_CAP)
		else $error("steering strength above cap");

	a_component_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(d2_valid && !d2_side.degen && d2_side.func != FN_NONE)
		|-> (d2_quo[0] <= d2_side.mstr && d2_quo[1] <= d2_side.mstr))
		else $error("direction component exceeds strength");

	a_live_length: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s14 && !c_s14.degen && (c_s14.func == FN_SEEK || c_s14.func == FN_AVOID
		|| c_s14.func == FN_CHASE)) |-> c_s14.gs.lh != '0)
		else $error("zero length on a non-degenerate word");

endmodule
